FILE: rtl/core/binary_3x3_neighborhood_lut_filter_macros.svh
// assertion macros for the neighborhood filter
`ifndef BINARY_3X3_NEIGHBORHOOD_LUT_FILTER_MACROS_SVH
`define BINARY_3X3_NEIGHBORHOOD_LUT_FILTER_MACROS_SVH
`ifndef SYNTHESIS
`define BNLF_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bnlf: property violated");
`define BNLF_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("bnlf: forbidden condition seen");
`else
`define BNLF_ASSERT(label, prop)
`define BNLF_NEVER(label, cond)
`endif
`endif

FILE: rtl/core/bnlf_pkg.sv
`timescale 1ns / 1ps
package bnlf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int DIM_W     = 11;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_OUT_W = $clog2(MAX_HEIGHT);

    localparam int CODE_W = 9;

    // configuration register indexes
    localparam logic [2:0] CFG_OPERATION  = 3'd0;
    localparam logic [2:0] CFG_CARE_MASK  = 3'd1;
    localparam logic [2:0] CFG_VALUE_MASK = 3'd2;
    localparam logic [2:0] CFG_WIDTH      = 3'd3;
    localparam logic [2:0] CFG_HEIGHT     = 3'd4;

    // operator codes
    localparam logic [2:0] OP_CLEAN     = 3'd0;
    localparam logic [2:0] OP_FILL      = 3'd1;
    localparam logic [2:0] OP_MAJORITY  = 3'd2;
    localparam logic [2:0] OP_ENDPOINTS = 3'd3;
    localparam logic [2:0] OP_SPUR      = 3'd4;
    localparam logic [2:0] OP_BRIDGE    = 3'd5;
    localparam logic [2:0] OP_HBREAK    = 3'd6;
    localparam logic [2:0] OP_HITMISS   = 3'd7;

    localparam logic [CODE_W-1:0] CENTER_BIT    = 9'h010;
    localparam logic [CODE_W-1:0] CROSS_MASK    = 9'h0AA;
    localparam logic [CODE_W-1:0] KEEP_LEFT_TWO = 9'h0DB;
    localparam logic [CODE_W-1:0] H_FULL_MASK   = 9'h1C7;
    localparam logic [CODE_W-1:0] H_CLEAR_MASK  = 9'h028;
    localparam logic [CODE_W-1:0] V_FULL_MASK   = 9'h16D;
    localparam logic [CODE_W-1:0] V_CLEAR_MASK  = 9'h082;
    localparam logic [3:0]        MAJORITY_MIN  = 4'd5;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd64;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd64;
    localparam logic [CODE_W-1:0] CARE_RESET  = 9'd511;
    localparam logic [CODE_W-1:0] VALUE_RESET = 9'd24;

    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam logic [CNT_W-1:0] FIFO_FULL  = CNT_W'(FIFO_DEPTH);
    // room for one item in flight plus one new item, two results each
    localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(FIFO_DEPTH - 4);

    typedef struct packed {
        logic                 pixel;
        logic [COL_W-1:0]     column;
        logic [ROW_OUT_W-1:0] row;
        logic                 last_of_run;
        logic                 frame_done;
    } result_t;

    typedef struct packed {
        logic    wr0;
        logic    wr1;
        result_t r0;
        result_t r1;
    } push_t;

    function automatic logic cells_adjacent(input int a, input int b);
        int dx;
        int dy;
        dx = (a % 3) - (b % 3);
        dy = (a / 3) - (b / 3);
        return (a != b) && (dx >= -1) && (dx <= 1) && (dy >= -1) && (dy <= 1);
    endfunction

    // bit n is set when the eight neighbors coded by n form two or more
    // 8-connected groups, so a set center would join them
    function automatic logic [255:0] build_bridge_table();
        logic [255:0]      tbl;
        logic [CODE_W-1:0] left;
        logic [CODE_W-1:0] region;
        int                groups;
        tbl = '0;
        for (int n = 0; n < 256; n++) begin
            left = {n[7:4], 1'b0, n[3:0]};
            groups = 0;
            for (int s = 0; s < CODE_W; s++) begin
                if (left[s]) begin
                    region = '0;
                    region[s] = 1'b1;
                    for (int it = 0; it < CODE_W; it++) begin
                        for (int i = 0; i < CODE_W; i++) begin
                            for (int j = 0; j < CODE_W; j++) begin
                                if (region[i] && left[j] && cells_adjacent(i, j)) begin
                                    region[j] = 1'b1;
                                end
                            end
                        end
                    end
                    left = left & ~region;
                    groups = groups + 1;
                end
            end
            tbl[n] = (groups >= 2);
        end
        return tbl;
    endfunction

    localparam logic [255:0] BRIDGE_TABLE = build_bridge_table();

    function automatic logic apply_op(
        input logic [2:0]        op,
        input logic [CODE_W-1:0] care,
        input logic [CODE_W-1:0] value,
        input logic [CODE_W-1:0] code
    );
        logic       c;
        logic [3:0] all_ones;
        logic [3:0] nb;
        logic       h_shape;
        logic       v_shape;
        logic       res;
        c = code[4];
        all_ones = '0;
        for (int i = 0; i < CODE_W; i++) begin
            all_ones = all_ones + {3'b000, code[i]};
        end
        nb = all_ones - {3'b000, c};
        h_shape = ((code & H_FULL_MASK) == H_FULL_MASK) && ((code & H_CLEAR_MASK) == '0);
        v_shape = ((code & V_FULL_MASK) == V_FULL_MASK) && ((code & V_CLEAR_MASK) == '0);
        unique case (op)
            OP_CLEAN:     res = c && (nb != 4'd0);
            OP_FILL:      res = c || ((code & CROSS_MASK) == CROSS_MASK);
            OP_MAJORITY:  res = (all_ones >= MAJORITY_MIN);
            OP_ENDPOINTS: res = c && (nb == 4'd1);
            OP_SPUR:      res = c && (nb != 4'd1);
            OP_BRIDGE:    res = c || BRIDGE_TABLE[{code[8:5], code[3:0]}];
            OP_HBREAK:    res = c && !(h_shape || v_shape);
            OP_HITMISS:   res = (((code ^ value) & care) == '0);
            default:      res = 1'b0;
        endcase
        return res;
    endfunction

endpackage

FILE: rtl/core/bnlf_result_fifo.sv
`timescale 1ns / 1ps
`include "binary_3x3_neighborhood_lut_filter_macros.svh"
module bnlf_result_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  bnlf_pkg::push_t   push,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output bnlf_pkg::result_t head
);

    bnlf_pkg::result_t               entry_reg [bnlf_pkg::FIFO_DEPTH];
    logic [bnlf_pkg::PTR_W-1:0]      wr_ptr_reg;
    logic [bnlf_pkg::PTR_W-1:0]      wr_ptr_next;
    logic [bnlf_pkg::PTR_W-1:0]      wr_ptr_plus1;
    logic [bnlf_pkg::PTR_W-1:0]      rd_ptr_reg;
    logic [bnlf_pkg::PTR_W-1:0]      rd_ptr_next;
    logic [bnlf_pkg::CNT_W-1:0]      count_reg;
    logic [bnlf_pkg::CNT_W-1:0]      count_next;
    logic [bnlf_pkg::CNT_W-1:0]      n_push;
    logic                            pop;

    assign out_valid    = (count_reg != '0);
    assign pop          = out_valid && out_ready;
    assign room         = (count_reg <= bnlf_pkg::ROOM_LIMIT);
    assign head         = entry_reg[rd_ptr_reg];
    assign wr_ptr_plus1 = wr_ptr_reg + bnlf_pkg::PTR_W'(1);
    assign n_push       = bnlf_pkg::CNT_W'(push.wr0) + bnlf_pkg::CNT_W'(push.wr1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + bnlf_pkg::PTR_W'(n_push);
        rd_ptr_next = pop ? rd_ptr_reg + bnlf_pkg::PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + n_push - bnlf_pkg::CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.wr0)
        begin
            entry_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.wr1)
        begin
            entry_reg[wr_ptr_plus1] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `BNLF_NEVER(a_fifo_overflow, count_reg > bnlf_pkg::FIFO_FULL)
    `BNLF_ASSERT(a_pair_order, push.wr1 |-> push.wr0 && !push.r0.last_of_run && push.r1.last_of_run)
    `BNLF_ASSERT(a_single_is_last, push.wr0 && !push.wr1 |-> push.r0.last_of_run)

endmodule

FILE: rtl/core/binary_3x3_neighborhood_lut_filter.sv
`timescale 1ns / 1ps
// one pixel request accepted per clock while the result queue has room; an item in
// the last column of a row pushes two results, so sustained output is one result per clock while out_ready is high
// a result is formed in the update stage registered at accept and then written into the output queue;
// it trails the input stream by one row and one column (one drain row ends a frame)
// line buffers: one 1024 x 2 bit ram, read at accept, written back the next cycle
// reset clears counters, window and config; line buffer contents stay undefined
module binary_3x3_neighborhood_lut_filter (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             pixel_in,
    input  logic                             frame_start,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             pixel_out,
    output logic [bnlf_pkg::COL_W-1:0]       out_column,
    output logic [bnlf_pkg::ROW_OUT_W-1:0]   out_row,
    output logic                             last_of_run,
    output logic                             frame_done,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [2:0]                       cfg_index,
    input  logic [bnlf_pkg::DIM_W-1:0]       cfg_data
);

    // configuration
    logic [2:0]                      operation_reg;
    logic [bnlf_pkg::CODE_W-1:0]     care_reg;
    logic [bnlf_pkg::CODE_W-1:0]     value_reg;
    logic [bnlf_pkg::DIM_W-1:0]      width_reg;
    logic [bnlf_pkg::DIM_W-1:0]      height_reg;
    logic [bnlf_pkg::DIM_W-1:0]      w_eff;
    logic [bnlf_pkg::DIM_W-1:0]      h_eff;

    // position counters
    logic [bnlf_pkg::COL_W-1:0]      col_reg;
    logic [bnlf_pkg::ROW_W-1:0]      row_reg;
    logic [bnlf_pkg::COL_W-1:0]      col_next;
    logic [bnlf_pkg::ROW_W-1:0]      row_next;

    // accept stage
    logic                            accept;
    logic [bnlf_pkg::COL_W-1:0]      col_a;
    logic [bnlf_pkg::ROW_W-1:0]      row_a;
    logic                            wrap_a;
    logic [bnlf_pkg::ROW_W-1:0]      row_b;
    logic [bnlf_pkg::COL_W-1:0]      col_s;
    logic [bnlf_pkg::ROW_W-1:0]      row_s;
    logic                            px_s;
    logic [bnlf_pkg::DIM_W-1:0]      col_inc;
    logic [bnlf_pkg::ROW_W-1:0]      row_inc;
    logic                            row_end_s;

    // line buffer ram: bit 0 row above, bit 1 two rows above
    logic [1:0]                      line_mem [bnlf_pkg::MAX_WIDTH];
    logic [1:0]                      rd_data_reg;
    logic                            fwd_hit_reg;
    logic [1:0]                      fwd_data_reg;

    // update stage
    logic                            v1_reg;
    logic [bnlf_pkg::COL_W-1:0]      col1_reg;
    logic [bnlf_pkg::ROW_W-1:0]      row1_reg;
    logic                            px1_reg;
    logic                            last1_reg;
    logic                            drain1_reg;
    logic [bnlf_pkg::CODE_W-1:0]     window_reg;
    logic [bnlf_pkg::CODE_W-1:0]     window_next;
    logic [bnlf_pkg::CODE_W-1:0]     window_base;
    logic [bnlf_pkg::CODE_W-1:0]     code_tail;
    logic [1:0]                      line_q;
    logic [1:0]                      wr_data;
    logic                            top_px;
    logic                            mid_px;
    logic [bnlf_pkg::ROW_W-1:0]      row_m1;
    logic                            r0_valid;
    logic                            r1_valid;
    bnlf_pkg::result_t               res0;
    bnlf_pkg::result_t               res1;
    bnlf_pkg::push_t                 push;
    logic                            room;
    bnlf_pkg::result_t               head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            operation_reg <= bnlf_pkg::OP_CLEAN;
            care_reg      <= bnlf_pkg::CARE_RESET;
            value_reg     <= bnlf_pkg::VALUE_RESET;
            width_reg     <= bnlf_pkg::WIDTH_RESET;
            height_reg    <= bnlf_pkg::HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                bnlf_pkg::CFG_OPERATION:  operation_reg <= cfg_data[2:0];
                bnlf_pkg::CFG_CARE_MASK:  care_reg      <= cfg_data[bnlf_pkg::CODE_W-1:0];
                bnlf_pkg::CFG_VALUE_MASK: value_reg     <= cfg_data[bnlf_pkg::CODE_W-1:0];
                bnlf_pkg::CFG_WIDTH:      width_reg     <= cfg_data;
                bnlf_pkg::CFG_HEIGHT:     height_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // zero acts as one, large values clamp to the buffer size
    always_comb
    begin
        if (width_reg == '0)
            w_eff = bnlf_pkg::DIM_W'(1);
        else if (width_reg > bnlf_pkg::DIM_W'(bnlf_pkg::MAX_WIDTH))
            w_eff = bnlf_pkg::DIM_W'(bnlf_pkg::MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg == '0)
            h_eff = bnlf_pkg::DIM_W'(1);
        else if (height_reg > bnlf_pkg::DIM_W'(bnlf_pkg::MAX_HEIGHT))
            h_eff = bnlf_pkg::DIM_W'(bnlf_pkg::MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    assign in_ready = room;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        col_a     = frame_start ? '0 : col_reg;
        row_a     = frame_start ? '0 : row_reg;
        // counters left past the end by a size change wrap here
        wrap_a    = ({1'b0, col_a} >= w_eff);
        col_s     = wrap_a ? '0 : col_a;
        row_b     = wrap_a ? row_a + bnlf_pkg::ROW_W'(1) : row_a;
        row_s     = (row_b > h_eff) ? '0 : row_b;
        px_s      = (row_s < h_eff) && pixel_in;
        col_inc   = {1'b0, col_s} + bnlf_pkg::DIM_W'(1);
        row_inc   = row_s + bnlf_pkg::ROW_W'(1);
        row_end_s = (col_inc >= w_eff);
        if (row_end_s)
        begin
            col_next = '0;
            row_next = (row_inc > h_eff) ? '0 : row_inc;
        end
        else
        begin
            col_next = col_inc[bnlf_pkg::COL_W-1:0];
            row_next = row_s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            v1_reg     <= 1'b0;
            window_reg <= '0;
        end
        else
        begin
            v1_reg <= accept;
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (v1_reg)
            begin
                window_reg <= window_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col1_reg   <= col_s;
            row1_reg   <= row_s;
            px1_reg    <= px_s;
            last1_reg  <= row_end_s;
            drain1_reg <= (row_s == h_eff);
            // the write from the item now finishing lands after this read
            fwd_hit_reg  <= v1_reg && (col1_reg == col_s);
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= line_mem[col_s];
        end
        if (v1_reg)
        begin
            line_mem[col1_reg] <= wr_data;
        end
    end

    always_comb
    begin
        line_q      = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        top_px      = (row1_reg >= bnlf_pkg::ROW_W'(2)) && line_q[1];
        mid_px      = (row1_reg != '0) && line_q[0];
        wr_data     = {line_q[0], px1_reg};
        window_base = (col1_reg == '0) ? '0 : window_reg;
        window_next = ((window_base >> 1) & bnlf_pkg::KEEP_LEFT_TWO)
                      | {px1_reg, 2'b00, mid_px, 2'b00, top_px, 2'b00};
        // right edge: shift once more with zero padding
        code_tail   = (window_next >> 1) & bnlf_pkg::KEEP_LEFT_TWO;
        row_m1      = row1_reg - bnlf_pkg::ROW_W'(1);
        r0_valid    = v1_reg && (row1_reg != '0) && (col1_reg != '0);
        r1_valid    = v1_reg && (row1_reg != '0) && last1_reg;

        res0.pixel       = bnlf_pkg::apply_op(operation_reg, care_reg, value_reg, window_next);
        res0.column      = col1_reg - bnlf_pkg::COL_W'(1);
        res0.row         = row_m1[bnlf_pkg::ROW_OUT_W-1:0];
        res0.last_of_run = !r1_valid;
        res0.frame_done  = 1'b0;

        res1.pixel       = bnlf_pkg::apply_op(operation_reg, care_reg, value_reg, code_tail);
        res1.column      = col1_reg;
        res1.row         = row_m1[bnlf_pkg::ROW_OUT_W-1:0];
        res1.last_of_run = 1'b1;
        res1.frame_done  = drain1_reg;

        push.wr0 = r0_valid || r1_valid;
        push.wr1 = r0_valid && r1_valid;
        push.r0  = r0_valid ? res0 : res1;
        push.r1  = res1;
    end

    bnlf_result_fifo u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign pixel_out   = head.pixel;
    assign out_column  = head.column;
    assign out_row     = head.row;
    assign last_of_run = head.last_of_run;
    assign frame_done  = head.frame_done;

endmodule
